// ===== hw/rtl/pss_pkg.sv =====
// Package for the profile sample statistics block.
// Holds the transaction payload types, command and status codes, and divider types.
// No dependencies.
`default_nettype none

package pss_pkg;

  localparam int ShareFracBits = 16;
  localparam int ShareW        = 4 + ShareFracBits;
  localparam int DivStepsW     = 6;

  localparam logic [ShareW-1:0]    ShareMax  = {ShareW{1'b1}};
  localparam logic [DivStepsW-1:0] TimeSteps = DivStepsW'(32);
  localparam logic [DivStepsW-1:0] ShareSteps = DivStepsW'(ShareW);

  localparam logic [1:0] CmdOpen   = 2'd0;
  localparam logic [1:0] CmdClose  = 2'd1;
  localparam logic [1:0] CmdUpdate = 2'd2;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StMisuse  = 2'd1;
  localparam logic [1:0] StSkipped = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] interval_us;
    logic [31:0] frame_span_us;
  } pss_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       calls;
    logic [31:0]       frames;
    logic [31:0]       mean_usecs;
    logic [31:0]       least_usecs;
    logic [31:0]       most_usecs;
    logic [ShareW-1:0] mean_share;
    logic [ShareW-1:0] least_share;
    logic [ShareW-1:0] most_share;
  } pss_out_t;

  typedef struct packed {
    logic                 start;
    logic [32:0]          hi;
    logic [31:0]          lo;
    logic [32:0]          den;
    logic [DivStepsW-1:0] steps;
  } pss_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } pss_div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pss_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// The dividend is given as a high part below the divisor and a left-aligned low word.
// Depends on pss_pkg.
`default_nettype none

module pss_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pss_pkg::pss_div_req_t req_i,
  output pss_pkg::pss_div_rsp_t      rsp_o
);
  import pss_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DivStepsW-1:0] cnt_q;
  logic [32:0]          rem_q;
  logic [31:0]          lo_q;
  logic [32:0]          den_q;

  logic [33:0] shifted;
  logic        ge;
  logic [33:0] diff;

  assign shifted = {rem_q, lo_q[31]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivStepsW'(1);
        if (cnt_q == DivStepsW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= req_i.hi;
      lo_q  <= req_i.lo;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[32:0] : shifted[32:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = lo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pss_stats.sv =====
// Statistics state and command sequencer of the profile sample statistics block.
// Drives the shared multiplier and the shared divider through the update steps.
// Depends on pss_pkg.
`default_nettype none

module pss_stats (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pss_pkg::pss_in_t      in_data_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ack_i,
  output pss_pkg::pss_out_t          res_data_o,
  output pss_pkg::pss_div_req_t      div_req_o,
  input  wire pss_pkg::pss_div_rsp_t div_rsp_i
);
  import pss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_T, S_ADD_T, S_DIV_T, S_SHARE, S_DIV_S,
    S_MUL_S, S_ADD_S, S_DIV_A, S_DONE
  } state_e;

  state_e            state_q;
  logic [1:0]        status_q;
  logic              section_open_q;
  logic              profiled_q;
  logic [31:0]       frame_time_q;
  logic [31:0]       call_total_q;
  logic [31:0]       frame_total_q;
  logic [31:0]       avg_time_q;
  logic [31:0]       min_time_q;
  logic [31:0]       max_time_q;
  logic [ShareW-1:0] avg_share_q;
  logic [ShareW-1:0] min_share_q;
  logic [ShareW-1:0] max_share_q;
  logic [31:0]       whole_q;
  logic [ShareW-1:0] share_q;
  logic [63:0]       prod_q;
  logic [64:0]       num_q;
  logic              div_go_q;

  logic              accept;
  logic              first;
  logic [31:0]       mul_a;
  logic [63:0]       prod_w;
  logic [32:0]       close_sum;
  logic              share_sat;
  logic [ShareW-1:0] quot_share;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign first      = (frame_total_q == 32'd0);
  assign mul_a      = (state_q == S_MUL_T) ? avg_time_q : 32'(avg_share_q);
  assign prod_w     = mul_a * frame_total_q;
  assign close_sum  = {1'b0, frame_time_q} + {1'b0, in_data_i.interval_us};
  assign share_sat  = {4'b0000, frame_time_q} >= {whole_q, 4'b0000};
  assign quot_share = div_rsp_i.quot[ShareW-1:0];

  always_comb begin
    div_req_o.start = div_go_q;
    div_req_o.den   = {1'b0, frame_total_q} + 33'd1;
    case (state_q)
      S_DIV_T: begin
        div_req_o.hi    = num_q[64:32];
        div_req_o.lo    = num_q[31:0];
        div_req_o.steps = TimeSteps;
      end
      S_DIV_S: begin
        div_req_o.den   = {1'b0, whole_q};
        div_req_o.hi    = 33'(frame_time_q[31:4]);
        div_req_o.lo    = {frame_time_q[3:0], 28'd0};
        div_req_o.steps = ShareSteps;
      end
      default: begin
        div_req_o.hi    = 33'(num_q >> ShareW);
        div_req_o.lo    = 32'(num_q[ShareW-1:0]) << (32 - ShareW);
        div_req_o.steps = ShareSteps;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      status_q       <= StDone;
      section_open_q <= 1'b0;
      profiled_q     <= 1'b0;
      frame_time_q   <= '0;
      call_total_q   <= '0;
      frame_total_q  <= '0;
      avg_time_q     <= '0;
      min_time_q     <= '0;
      max_time_q     <= '0;
      avg_share_q    <= '0;
      min_share_q    <= '0;
      max_share_q    <= '0;
      whole_q        <= '0;
      share_q        <= '0;
      prod_q         <= '0;
      num_q          <= '0;
      div_go_q       <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q  <= S_DONE;
            status_q <= StMisuse;
            case (in_data_i.command)
              CmdOpen: begin
                if (!section_open_q) begin
                  section_open_q <= 1'b1;
                  profiled_q     <= 1'b1;
                  if (call_total_q != '1) begin
                    call_total_q <= call_total_q + 32'd1;
                  end
                  status_q <= StDone;
                end
              end
              CmdClose: begin
                if (section_open_q) begin
                  section_open_q <= 1'b0;
                  frame_time_q   <= close_sum[32] ? '1 : close_sum[31:0];
                  status_q       <= StDone;
                end
              end
              CmdUpdate: begin
                if (section_open_q) begin
                  status_q <= StMisuse;
                end else if (!profiled_q) begin
                  status_q <= StSkipped;
                end else begin
                  whole_q <= in_data_i.frame_span_us;
                  state_q <= S_MUL_T;
                end
              end
              default: begin
                status_q <= StMisuse;
              end
            endcase
          end
        end
        S_MUL_T: begin
          prod_q  <= prod_w;
          state_q <= S_ADD_T;
        end
        S_ADD_T: begin
          num_q    <= {1'b0, prod_q} + 65'(frame_time_q);
          div_go_q <= 1'b1;
          state_q  <= S_DIV_T;
        end
        S_DIV_T: begin
          if (div_rsp_i.done) begin
            avg_time_q <= div_rsp_i.quot;
            if (first || frame_time_q < min_time_q) begin
              min_time_q <= frame_time_q;
            end
            if (first || frame_time_q > max_time_q) begin
              max_time_q <= frame_time_q;
            end
            state_q <= S_SHARE;
          end
        end
        S_SHARE: begin
          if (share_sat) begin
            share_q <= ShareMax;
            state_q <= S_MUL_S;
          end else begin
            div_go_q <= 1'b1;
            state_q  <= S_DIV_S;
          end
        end
        S_DIV_S: begin
          if (div_rsp_i.done) begin
            share_q <= quot_share;
            state_q <= S_MUL_S;
          end
        end
        S_MUL_S: begin
          prod_q  <= prod_w;
          state_q <= S_ADD_S;
        end
        S_ADD_S: begin
          num_q    <= {1'b0, prod_q} + 65'(share_q);
          div_go_q <= 1'b1;
          state_q  <= S_DIV_A;
        end
        S_DIV_A: begin
          if (div_rsp_i.done) begin
            avg_share_q <= quot_share;
            if (first || share_q < min_share_q) begin
              min_share_q <= share_q;
            end
            if (first || share_q > max_share_q) begin
              max_share_q <= share_q;
            end
            if (frame_total_q != '1) begin
              frame_total_q <= frame_total_q + 32'd1;
            end
            profiled_q   <= 1'b0;
            frame_time_q <= '0;
            status_q     <= StDone;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o             = (state_q == S_DONE);
  assign res_data_o.status       = status_q;
  assign res_data_o.calls        = call_total_q;
  assign res_data_o.frames       = frame_total_q;
  assign res_data_o.mean_usecs   = avg_time_q;
  assign res_data_o.least_usecs  = min_time_q;
  assign res_data_o.most_usecs   = max_time_q;
  assign res_data_o.mean_share   = avg_share_q;
  assign res_data_o.least_share  = min_share_q;
  assign res_data_o.most_share   = max_share_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("Divider started while still busy.");

  a_open_implies_profiled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    section_open_q |-> profiled_q)
    else $error("Section open without being marked profiled.");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && frame_total_q != 32'd0) |->
    (min_time_q <= max_time_q && min_share_q <= max_share_q))
    else $error("Minimum exceeds maximum.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ack_i) |=> (res_valid_o && $stable(res_data_o)))
    else $error("Pending result changed before it was taken.");

endmodule

`default_nettype wire

// ===== hw/rtl/profile_sample_statistics_top.sv =====
// Top level of the profile sample statistics block.
// Instantiates the sequencer pss_stats, the shared divider pss_div and the output register.
// Depends on pss_pkg, pss_stats and pss_div.
`default_nettype none

// Keeps timing statistics of one profiled code section. Each input transaction carries
// a command (open, close, or end frame and update) and yields exactly one result
// transaction with a status and the statistics after the command. Open, close and
// rejected commands go straight to the done state and then to the output register. A
// successful update runs the shared restoring divider, which resolves one quotient bit
// per cycle, up to three times: for the mean time, for the share of the frame and for
// the mean share, the first and last each after a multiply and an add. When the share
// saturates, the second division is skipped. The input is ready only while no
// transaction is in progress and takes the next transaction once the result moves to
// the output register; a finished result waits in the output register while the next
// transaction is accepted, and a further result waits while it is still full.

module profile_sample_statistics_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pss_pkg::pss_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pss_pkg::pss_out_t      out_data_o
);
  import pss_pkg::*;

  pss_div_req_t div_req;
  pss_div_rsp_t div_rsp;
  logic         res_valid;
  logic         res_ack;
  pss_out_t     res_data;
  logic         out_valid_q;
  pss_out_t     out_data_q;

  pss_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ack_i   (res_ack),
    .res_data_o  (res_data),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  pss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== verif/tb_profile_sample_statistics_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for profile_sample_statistics_top: directed table, then random frames.
// Results are compared against a local predictor and the table. Depends on pss_pkg and the RTL.

module tb_profile_sample_statistics_top;
  import pss_pkg::*;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int TotalItems = 950;
  localparam int HoldStart = 200;
  localparam int DrainStart = 500;
  localparam int CalmStart = 850;
  localparam int HoldCycles = 400;
  localparam int IdleLimit = 3000;
  localparam int DirCount = 24;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] elapsed;
    logic [31:0] whole;
    logic        fixed_exp;
    logic [1:0]  st;
    logic [31:0] calls;
    logic [31:0] frames;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    '{CmdClose,   32'h12345678, 32'h9ABCDEF0, 1'b1, StMisuse,  32'd0, 32'd0},
    '{CmdUpdate,  32'h00000000, 32'hFFFFFFFF, 1'b1, StSkipped, 32'd0, 32'd0},
    '{CmdUnknown, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, StMisuse,  32'd0, 32'd0},
    '{CmdOpen,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, StDone,    32'd1, 32'd0},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b1, StMisuse,  32'd1, 32'd0},
    '{CmdUpdate,  32'h00000000, 32'd100,      1'b1, StMisuse,  32'd1, 32'd0},
    '{CmdClose,   32'hFFFFFFFF, 32'h00000000, 1'b1, StDone,    32'd1, 32'd0},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b1, StDone,    32'd2, 32'd0},
    '{CmdClose,   32'hFFFFFFFF, 32'h00000000, 1'b1, StDone,    32'd2, 32'd0},
    '{CmdUpdate,  32'h00000000, 32'hFFFFFFFF, 1'b1, StDone,    32'd2, 32'd1},
    '{CmdUpdate,  32'h00000000, 32'd5,        1'b1, StSkipped, 32'd2, 32'd1},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b1, StDone,    32'd3, 32'd1},
    '{CmdClose,   32'h00000000, 32'h00000000, 1'b1, StDone,    32'd3, 32'd1},
    '{CmdUpdate,  32'h00000000, 32'h00000000, 1'b1, StDone,    32'd3, 32'd2},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b1, StDone,    32'd4, 32'd2},
    '{CmdClose,   32'd1000,     32'h00000000, 1'b1, StDone,    32'd4, 32'd2},
    '{CmdUpdate,  32'h00000000, 32'd10,       1'b1, StDone,    32'd4, 32'd3},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b1, StDone,    32'd5, 32'd3},
    '{CmdUnknown, 32'h00000000, 32'h00000000, 1'b1, StMisuse,  32'd5, 32'd3},
    '{CmdClose,   32'd1,        32'h00000000, 1'b1, StDone,    32'd5, 32'd3},
    '{CmdUpdate,  32'h00000000, 32'hFFFFFFFF, 1'b1, StDone,    32'd5, 32'd4},
    '{CmdOpen,    32'h00000000, 32'h00000000, 1'b0, StDone,    32'd0, 32'd0},
    '{CmdClose,   32'h00010000, 32'h00000000, 1'b0, StDone,    32'd0, 32'd0},
    '{CmdUpdate,  32'h00000000, 32'h00020000, 1'b0, StDone,    32'd0, 32'd0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  pss_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  pss_out_t out_data_o;

  profile_sample_statistics_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  logic              sec_open = 1'b0;
  logic              in_frame = 1'b0;
  logic [31:0]       frame_acc = '0;
  logic [31:0]       call_cnt = '0;
  logic [31:0]       frame_cnt = '0;
  logic [31:0]       avg_tm = '0;
  logic [31:0]       min_tm = '0;
  logic [31:0]       max_tm = '0;
  logic [ShareW-1:0] avg_shr = '0;
  logic [ShareW-1:0] min_shr = '0;
  logic [ShareW-1:0] max_shr = '0;

  pss_out_t pending_results[$];
  int       err_cnt = 0;
  int       accepted_cnt = 0;
  int       items_sent = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pss_out_t apply_command(pss_in_t item);
    pss_out_t    r;
    logic [63:0] n;
    logic [63:0] n1;
    logic [63:0] sum;
    logic [63:0] shr;
    logic [31:0] t;
    r.status = StMisuse;
    case (item.command)
      CmdOpen: begin
        if (!sec_open) begin
          sec_open = 1'b1;
          in_frame = 1'b1;
          if (call_cnt != 32'hFFFFFFFF) call_cnt = call_cnt + 32'd1;
          r.status = StDone;
        end
      end
      CmdClose: begin
        if (sec_open) begin
          sum = {32'd0, frame_acc} + {32'd0, item.interval_us};
          sec_open = 1'b0;
          frame_acc = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
          r.status = StDone;
        end
      end
      CmdUpdate: begin
        if (sec_open) begin
          r.status = StMisuse;
        end else if (!in_frame) begin
          r.status = StSkipped;
        end else begin
          n = {32'd0, frame_cnt};
          n1 = n + 64'd1;
          t = frame_acc;
          sum = ({32'd0, t} + {32'd0, avg_tm} * n) / n1;
          avg_tm = sum[31:0];
          if (n == 0 || t < min_tm) min_tm = t;
          if (n == 0 || t > max_tm) max_tm = t;
          if (item.frame_span_us == 32'd0) begin
            shr = 64'(ShareMax);
          end else begin
            shr = ({32'd0, t} << ShareFracBits) / {32'd0, item.frame_span_us};
            if (shr > 64'(ShareMax)) shr = 64'(ShareMax);
          end
          sum = (shr + 64'(avg_shr) * n) / n1;
          avg_shr = sum[ShareW-1:0];
          if (n == 0 || shr[ShareW-1:0] < min_shr) min_shr = shr[ShareW-1:0];
          if (n == 0 || shr[ShareW-1:0] > max_shr) max_shr = shr[ShareW-1:0];
          if (frame_cnt != 32'hFFFFFFFF) frame_cnt = frame_cnt + 32'd1;
          in_frame = 1'b0;
          frame_acc = '0;
          r.status = StDone;
        end
      end
      default: ;
    endcase
    r.calls = call_cnt;
    r.frames = frame_cnt;
    r.mean_usecs = avg_tm;
    r.least_usecs = min_tm;
    r.most_usecs = max_tm;
    r.mean_share = avg_shr;
    r.least_share = min_shr;
    r.most_share = max_shr;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      err_cnt++;
    end
  endtask

  task automatic compare_result(pss_out_t expr, pss_out_t got);
    check_field("status", 32'(expr.status), 32'(got.status));
    check_field("calls", expr.calls, got.calls);
    check_field("frames", expr.frames, got.frames);
    check_field("mean_usecs", expr.mean_usecs, got.mean_usecs);
    check_field("least_usecs", expr.least_usecs, got.least_usecs);
    check_field("most_usecs", expr.most_usecs, got.most_usecs);
    check_field("mean_share", 32'(expr.mean_share), 32'(got.mean_share));
    check_field("least_share", 32'(expr.least_share), 32'(got.least_share));
    check_field("most_share", 32'(expr.most_share), 32'(got.most_share));
  endtask

  always @(posedge clk_i) begin
    pss_out_t expr;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding, status %0d", out_data_o.status);
        err_cnt++;
      end else begin
        compare_result(pending_results.pop_front(), out_data_o);
      end
    end
    if (in_valid_i && in_ready_o) begin
      expr = apply_command(in_data_i);
      if (accepted_cnt < DirCount && DirRows[accepted_cnt].fixed_exp) begin
        expr.status = DirRows[accepted_cnt].st;
        expr.calls = DirRows[accepted_cnt].calls;
        expr.frames = DirRows[accepted_cnt].frames;
      end
      pending_results.push_back(expr);
      accepted_cnt++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (calm || $urandom_range(2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [31:0] elapsed, logic [31:0] whole);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{command: cmd, interval_us: elapsed, frame_span_us: whole};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (items_sent == HoldStart) hold_req = 1'b1;
    if (items_sent >= CalmStart) calm = 1'b1;
    if (items_sent == DrainStart) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending_results.size() != 0) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(3))
      0: return $urandom_range(0, 1000);
      1: return $urandom;
      2: return $urandom_range(0, 100000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] pick_whole(logic [63:0] sum);
    logic [63:0] w;
    case ($urandom_range(5))
      0: w = 64'd0;
      1: w = 64'($urandom);
      2: w = sum + (sum >> $urandom_range(0, 8));
      3: w = sum >> $urandom_range(0, 6);
      4: w = 64'hFFFFFFFF;
      default: w = 64'($urandom_range(1, 1000));
    endcase
    return (w > 64'hFFFFFFFF) ? 32'hFFFFFFFF : w[31:0];
  endfunction

  initial begin
    logic [63:0] sum;
    logic [31:0] el;
    int          pairs;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      send_item(DirRows[i].cmd, DirRows[i].elapsed, DirRows[i].whole);
    end

    while (items_sent < TotalItems) begin
      if ($urandom_range(9) == 0) begin
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        sum = '0;
        pairs = $urandom_range(0, 3);
        for (int p = 0; p < pairs; p++) begin
          el = pick_elapsed();
          sum = sum + {32'd0, el};
          send_item(CmdOpen, $urandom, $urandom);
          send_item(CmdClose, el, $urandom);
        end
        if (sum > 64'hFFFFFFFF) sum = 64'hFFFFFFFF;
        send_item(CmdUpdate, $urandom, pick_whole(sum));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
